### src/ritoa_pkg.sv
// ----------------------------------------------------------------------------
// ritoa_pkg
// Shared types, constants and helpers for the radix integer-to-ASCII unit.
// ----------------------------------------------------------------------------
package ritoa_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int CHUNK_BITS         = 8;

   localparam logic [5:0] MIN_RADIX = 6'd2;
   localparam logic [5:0] MAX_RADIX = 6'd36;

   localparam logic [1:0] MODE_FULL  = 2'd0;
   localparam logic [1:0] MODE_BYTE  = 2'd1;
   localparam logic [1:0] MODE_HALF  = 2'd2;

   localparam logic [6:0] CHAR_ZERO   = 7'h30;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [5:0] DECIMAL_DIGITS = 6'd10;

   typedef struct packed {
      logic [63:0] value;
      logic [5:0]  radix;
      logic [1:0]  length_mode;
   } req_type;

   typedef struct packed {
      logic [6:0] digit_char;
      logic       last_digit;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   function automatic logic [6:0] digit_to_char(input logic [5:0] digit);
      logic [6:0] ch;
      if (digit < DECIMAL_DIGITS) begin
         ch = CHAR_ZERO + {1'b0, digit};
      end else begin
         ch = CHAR_LOWER_A + {1'b0, digit - DECIMAL_DIGITS};
      end
      return ch;
   endfunction

endpackage

### src/ritoa_digit_ram.sv
// ----------------------------------------------------------------------------
// ritoa_digit_ram
// Digit store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ritoa_digit_ram #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [5:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [5:0]               rd_data
);

   logic [5:0] mem_ff [DEPTH];
   logic [5:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ritoa_divider.sv
// ----------------------------------------------------------------------------
// ritoa_divider
// Iterative restoring divider by a 6-bit radix, eight quotient bits a cycle.
// ----------------------------------------------------------------------------
module ritoa_divider #(
   parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [5:0]            radix,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [5:0]            remainder
);
   import ritoa_pkg::*;

   localparam int NSTEP = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int DW    = NSTEP * CHUNK_BITS;
   localparam int CW    = $clog2(NSTEP + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [5:0]    rem_ff, rem_in;
   logic [5:0]    radix_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;

   logic [DW-1:0] q_step;
   logic [5:0]    r_step;
   logic [6:0]    trial;

   always_comb begin
      q_step = quo_ff;
      r_step = rem_ff;
      trial  = 7'd0;
      for (int i = 0; i < CHUNK_BITS; i++) begin
         trial  = {r_step, q_step[DW-1]};
         q_step = {q_step[DW-2:0], 1'b0};
         if (trial >= {1'b0, radix_ff}) begin
            trial     = trial - {1'b0, radix_ff};
            q_step[0] = 1'b1;
         end
         r_step = trial[5:0];
      end
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = DW'(dividend);
         rem_in = 6'd0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = q_step;
         rem_in = r_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NSTEP - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         radix_ff <= radix;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

   a_done_not_running: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff || $past(start))
      else $error("divider done while still running");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      done_ff && radix_ff != 6'd0 |-> rem_ff < radix_ff)
      else $error("remainder not below radix");

endmodule

### src/radix_integer_to_ascii_unit.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_unit
// Converts an unsigned value to ASCII digits in radix 2..36, most significant
// digit first, one character per result strobe.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Digits come out
// one per cycle on rsp_strobe with no way to stall them, the final digit
// flagged by last_digit. The shared divider retires eight quotient bits a
// cycle and yields one digit per pass; digits are parked in a digit store
// and then read back in reverse order, one a cycle. The last digit is
// strobed in the first cycle with busy low.
module radix_integer_to_ascii_unit #(
   parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ritoa_pkg::req_type  req_payload,
   output logic                rsp_strobe,
   output ritoa_pkg::rsp_type  rsp_payload
);
   import ritoa_pkg::*;

   localparam int AW   = $clog2(VALUE_BITS);
   localparam int CNTW = $clog2(VALUE_BITS + 1);

   state_type       state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [5:0]      radix_ff, radix_in;
   logic            pend_ff, pend_in;
   logic            last_ff, last_in;

   logic [VALUE_BITS-1:0] value_masked;
   logic [5:0]            radix_clamped;
   logic                  accept;

   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [5:0]            div_radix;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [5:0]            div_rem;

   logic                  wr_en;
   logic                  rd_en;
   logic [5:0]            rd_data;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      value_masked = req_payload.value[VALUE_BITS-1:0];
      case (req_payload.length_mode)
         MODE_BYTE: value_masked = value_masked & VALUE_BITS'(64'hFF);
         MODE_HALF: value_masked = value_masked & VALUE_BITS'(64'hFFFF);
         default:   value_masked = value_masked;
      endcase
      if (req_payload.radix < MIN_RADIX) begin
         radix_clamped = MIN_RADIX;
      end else if (req_payload.radix > MAX_RADIX) begin
         radix_clamped = MAX_RADIX;
      end else begin
         radix_clamped = req_payload.radix;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      radix_in     = radix_ff;
      pend_in      = 1'b0;
      last_in      = 1'b0;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      div_radix    = radix_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               div_start    = 1'b1;
               div_dividend = value_masked;
               div_radix    = radix_clamped;
               radix_in     = radix_clamped;
               cnt_in       = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (div_quotient == '0) begin
                  idx_in   = cnt_ff[AW-1:0];
                  state_in = ST_EMIT;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            rd_en   = 1'b1;
            pend_in = 1'b1;
            last_in = (idx_ff == '0);
            idx_in  = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      radix_ff <= radix_in;
      last_ff  <= last_in;
   end

   ritoa_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (div_radix),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_rem)
   );

   ritoa_digit_ram #(
      .DEPTH (VALUE_BITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (div_rem),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rsp_strobe             = pend_ff;
   assign rsp_payload.digit_char = digit_to_char(rd_data);
   assign rsp_payload.last_digit = last_ff;

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_EMIT)
      else $error("digit strobed outside readout");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(VALUE_BITS))
      else $error("digit count beyond value width");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide phase");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && cnt_ff == '0)
      else $error("transaction accepted without going busy");

endmodule

### tb/sv/radix_integer_to_ascii_unit_tb.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_unit_tb
// Self-checking bench for the radix integer-to-ASCII unit. Each accepted
// conversion request is turned into its expected digit string by an in-bench
// predictor, and every strobed digit is checked in order against it. A short
// directed run covers extreme values, radices and length modes. Random runs
// follow, first with the sender idling lightly, then heavily, then not at all.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import ritoa_pkg::*;

   localparam int         VALUE_BITS       = VALUE_BITS_DEFAULT;
   localparam logic [1:0] MODE_SPARE       = 2'd3;
   localparam int         QUIET_LIMIT      = 5000;
   localparam int         DRAIN_CYCLES     = 16;
   localparam int         RANDOM_PER_PHASE = 83;
   localparam int         REPORT_LIMIT     = 10;

   class digit_tracker;
      rsp_type digits_due[$];
      int      mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void complain(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
         end
      endfunction

      function void note_request(req_type req);
         logic [63:0] v;
         logic [5:0]  base;
         logic [5:0]  digit;
         logic [5:0]  reversed[$];
         rsp_type     exp;
         v = req.value & ({64{1'b1}} >> (64 - VALUE_BITS));
         base = req.radix;
         if (base < MIN_RADIX) begin
            base = MIN_RADIX;
         end else if (base > MAX_RADIX) begin
            base = MAX_RADIX;
         end
         case (req.length_mode)
            MODE_BYTE: v = {56'd0, v[7:0]};
            MODE_HALF: v = {48'd0, v[15:0]};
            default: ;
         endcase
         do begin
            digit = 6'(v % {58'd0, base});
            reversed.push_front(digit);
            v = v / {58'd0, base};
         end while (v != 64'd0);
         foreach (reversed[k]) begin
            digit = reversed[k];
            if (digit < DECIMAL_DIGITS) begin
               exp.digit_char = CHAR_ZERO + {1'b0, digit};
            end else begin
               exp.digit_char = CHAR_LOWER_A - 7'd10 + {1'b0, digit};
            end
            exp.last_digit = (k == reversed.size() - 1);
            digits_due.push_back(exp);
         end
      endfunction

      function void check_digit(rsp_type got);
         rsp_type exp;
         if (digits_due.size() == 0) begin
            complain($sformatf("unexpected digit char=%h last=%b",
                               got.digit_char, got.last_digit));
         end else begin
            exp = digits_due.pop_front();
            if (got.digit_char !== exp.digit_char || got.last_digit !== exp.last_digit) begin
               complain($sformatf("char exp=%h got=%h, last exp=%b got=%b",
                                  exp.digit_char, got.digit_char,
                                  exp.last_digit, got.last_digit));
            end
         end
      endfunction

      function int pending();
         return digits_due.size();
      endfunction

      function bit clean();
         if (digits_due.size() != 0) begin
            complain($sformatf("%0d digits never arrived", digits_due.size()));
         end
         return mismatches == 0;
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   int           quiet_cycles = 0;
   digit_tracker tracker = new();

   radix_integer_to_ascii_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            tracker.check_digit(rsp_payload);
         end
         if (start && !busy) begin
            tracker.note_request(req_payload);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("radix_integer_to_ascii_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic idle_gap(input int pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_item(input logic [63:0] v, input logic [5:0] r,
                            input logic [1:0] m, input int pct);
      req_type req;
      idle_gap(pct);
      req.value       = v;
      req.radix       = r;
      req.length_mode = m;
      start       <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_digits();
      start <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   function automatic logic [63:0] rand_value(input logic [5:0] r);
      logic [63:0] v;
      logic [63:0] base;
      int          k;
      case ($urandom_range(5))
         0: v = {$urandom, $urandom};
         1: v = {$urandom, $urandom} >> $urandom_range(63);
         2: v = 64'($urandom_range(300));
         3: v = 64'd1 << $urandom_range(63);
         4: v = {64{1'b1}} >> $urandom_range(63);
         default: begin
            base = (r >= MIN_RADIX && r <= MAX_RADIX) ? 64'(r) : 64'd2;
            v = 64'd1;
            k = $urandom_range(1, 12);
            repeat (k) v = v * base;
            v = v - 64'($urandom_range(1));
         end
      endcase
      return v;
   endfunction

   initial begin
      logic [5:0] r;
      logic [1:0] m;
      int         pct;
      int         pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(64'd0, 6'd10, MODE_FULL, 0);
      send_item({64{1'b1}}, 6'd2, MODE_FULL, 0);
      send_item({64{1'b1}}, 6'd36, MODE_FULL, 0);
      send_item({64{1'b1}}, 6'd10, MODE_FULL, 0);
      send_item(64'h8000_0000_0000_0000, 6'd2, MODE_FULL, 0);
      send_item(64'd1, 6'd2, MODE_FULL, 0);
      send_item(64'd35, 6'd36, MODE_FULL, 0);
      send_item(64'd36, 6'd36, MODE_FULL, 0);
      send_item(64'd10, 6'd11, MODE_FULL, 0);
      send_item(64'd9, 6'd10, MODE_FULL, 0);
      send_item(64'h0123_4567_89ab_cdef, 6'd16, MODE_FULL, 0);
      send_item({64{1'b1}}, 6'd2, MODE_BYTE, 0);
      send_item(64'h1ff, 6'd10, MODE_BYTE, 0);
      send_item(64'h100, 6'd7, MODE_BYTE, 0);
      send_item(64'h1_0000, 6'd16, MODE_HALF, 0);
      send_item(64'h1_2345, 6'd16, MODE_HALF, 0);
      send_item({64{1'b1}}, 6'd36, MODE_HALF, 0);
      send_item(64'd255, 6'd0, MODE_FULL, 0);
      send_item(64'd255, 6'd1, MODE_FULL, 0);
      send_item(64'd1295, 6'd37, MODE_FULL, 0);
      send_item({64{1'b1}}, 6'd63, MODE_FULL, 0);
      send_item(64'hdead_beef_0000_0001, 6'd16, MODE_SPARE, 0);
      drain_digits();

      for (int phase = 0; phase < 3; phase++) begin
         pct = (phase == 0) ? 33 : (phase == 1) ? 88 : 0;
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            r = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                         : 6'($urandom_range(2, 36));
            pick = $urandom_range(9);
            m = (pick < 4) ? MODE_FULL : (pick < 6) ? MODE_BYTE :
                (pick < 8) ? MODE_HALF : (pick < 9) ? MODE_SPARE : 2'($urandom_range(3));
            send_item(rand_value(r), r, m, pct);
            if ($urandom_range(39) == 0) begin
               drain_digits();
            end
         end
         drain_digits();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.clean()) begin
         $display("radix_integer_to_ascii_unit verification clean");
      end else begin
         $display("radix_integer_to_ascii_unit verification failed");
      end
      $finish;
   end

endmodule

### files.f
src/ritoa_pkg.sv
src/ritoa_digit_ram.sv
src/ritoa_divider.sv
src/radix_integer_to_ascii_unit.sv
tb/sv/radix_integer_to_ascii_unit_tb.sv
